// ----- rtl/core/ppsc_pkg.sv -----
package ppsc_pkg;
   localparam int WORD_BITS_DEF = 48;
   localparam int FRAC_BITS_DEF = 24;
   localparam int STEP_BITS_DEF = 16;
   localparam int FIELD_BITS = 47;
   localparam int TH_BITS = 16;
   localparam int CFG_IDX_BITS = 3;

   localparam logic [CFG_IDX_BITS-1:0] REG_R = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_K = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_D = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_A = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_TH = 3'd4;
   localparam logic [CFG_IDX_BITS-1:0] REG_N0 = 3'd5;
   localparam logic [CFG_IDX_BITS-1:0] REG_C0 = 3'd6;
   localparam logic [CFG_IDX_BITS-1:0] REG_STEPS = 3'd7;

   localparam logic [FIELD_BITS-1:0] RST_R = 47'd8388608;
   localparam logic [FIELD_BITS-1:0] RST_K = 47'd16777216000;
   localparam logic [FIELD_BITS-1:0] RST_D = 47'd1677722;
   localparam logic [FIELD_BITS-1:0] RST_A = 47'd8388608;
   localparam logic [TH_BITS-1:0] RST_TH = 16'd1;
   localparam logic [FIELD_BITS-1:0] RST_N0 = 47'd1677721600;
   localparam logic [FIELD_BITS-1:0] RST_C0 = 47'd167772160;
   localparam logic [TH_BITS-1:0] RST_STEPS = 16'd1000;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_DIV,
      OP_ALU
   } op_type;

   localparam logic [4:0] UOP_NONE = 5'd0;
   localparam logic [4:0] UOP_MUL_PN = 5'd0;
   localparam logic [4:0] UOP_MUL_PN2 = 5'd1;
   localparam logic [4:0] UOP_MUL_TH = 5'd2;
   localparam logic [4:0] UOP_MUL_AF = 5'd3;
   localparam logic [4:0] UOP_MUL_GAIN = 5'd4;
   localparam logic [4:0] UOP_MUL_LOSS = 5'd5;
   localparam logic [4:0] UOP_MUL_RN = 5'd6;
   localparam logic [4:0] UOP_MUL_EAT = 5'd7;
   localparam logic [4:0] UOP_MUL_ADJ = 5'd8;
   localparam logic [4:0] UOP_DIV_F = 5'd0;
   localparam logic [4:0] UOP_DIV_RAT = 5'd1;
   localparam logic [4:0] UOP_ALU_DEN = 5'd0;
   localparam logic [4:0] UOP_ALU_NC = 5'd1;
   localparam logic [4:0] UOP_ALU_ADJ = 5'd2;
   localparam logic [4:0] UOP_ALU_STEP = 5'd3;

   typedef struct packed {
      op_type op;
      logic [4:0] uop;
   } cmd_type;

   typedef struct packed {
      logic unit_done;
      logic extinct;
   } sts_type;
endpackage

// ----- rtl/core/ppsc_mul.sv -----
module ppsc_mul #(
   parameter int WORD_BITS = ppsc_pkg::WORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [WORD_BITS-1:0]   x,
   input  logic [WORD_BITS-1:0]   y,
   output logic                   done,
   output logic [2*WORD_BITS-1:0] prod
);
   localparam int HB = (WORD_BITS + 1) / 2;
   localparam int XW = 2 * HB;

   logic [XW-1:0] x_ff, y_ff;
   logic [2*XW-1:0] acc_ff, acc_in;
   logic [1:0] cnt_ff;
   logic run_ff, done_ff;
   logic [HB-1:0] xa, ya;
   logic [2*HB-1:0] pp;
   logic [2*XW-1:0] ppx;

   always_comb begin
      xa = cnt_ff[1] ? x_ff[XW-1:HB] : x_ff[HB-1:0];
      ya = cnt_ff[0] ? y_ff[XW-1:HB] : y_ff[HB-1:0];
      pp = xa * ya;
      ppx = {{(2*XW-2*HB){1'b0}}, pp} << (HB * (32'(cnt_ff[1]) + 32'(cnt_ff[0])));
      acc_in = acc_ff + ppx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            x_ff <= XW'(x);
            y_ff <= XW'(y);
            acc_ff <= '0;
         end else if (run_ff) begin
            acc_ff <= acc_in;
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff[2*WORD_BITS-1:0];
endmodule

// ----- rtl/core/ppsc_div.sv -----
module ppsc_div #(
   parameter int WORD_BITS = ppsc_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = ppsc_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [WORD_BITS-1:0] x,
   input  logic [WORD_BITS-1:0] y,
   output logic                 done,
   output logic [WORD_BITS-1:0] quo
);
   localparam int NB = WORD_BITS + FRAC_BITS;
   localparam int CB = $clog2(NB + 1);
   localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};

   logic [NB-1:0] num_ff, q_ff;
   logic [WORD_BITS:0] rem_ff, rsh;
   logic [WORD_BITS-1:0] y_ff;
   logic [CB-1:0] cnt_ff;
   logic run_ff, done_ff;
   logic ge;

   always_comb begin
      rsh = {rem_ff[WORD_BITS-1:0], num_ff[NB-1]};
      ge = rsh >= {1'b0, y_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= CB'(NB);
            num_ff <= {x, {FRAC_BITS{1'b0}}};
            y_ff <= y;
            rem_ff <= '0;
            q_ff <= '0;
         end else if (run_ff) begin
            num_ff <= num_ff << 1;
            rem_ff <= ge ? rsh - {1'b0, y_ff} : rsh;
            q_ff <= {q_ff[NB-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CB'(1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo = (y_ff == '0 || q_ff > NB'(MAXV)) ? MAXV : q_ff[WORD_BITS-1:0];
endmodule

// ----- rtl/core/ppsc_datapath.sv -----
module ppsc_datapath #(
   parameter int WORD_BITS = ppsc_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = ppsc_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ppsc_pkg::cmd_type                 cmd,
   output ppsc_pkg::sts_type                 sts,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]   kill_rate,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]   reg_r,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]   reg_k,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]   reg_d,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]   reg_a,
   input  logic [ppsc_pkg::TH_BITS-1:0]      reg_th,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]   reg_n0,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]   reg_c0,
   output logic [ppsc_pkg::FIELD_BITS-1:0]   prey,
   output logic [ppsc_pkg::FIELD_BITS-1:0]   pred
);
   localparam int W = WORD_BITS;
   localparam int FB = ppsc_pkg::FIELD_BITS;
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

   // register file slots
   localparam int S_P = 0, S_N = 1, S_C = 2, S_PN2 = 3, S_F = 4, S_GAIN = 5;
   localparam int S_LOSS = 6, S_RAT = 7, S_RN = 8, S_EAT = 9, S_T = 10, S_DEN = 11;
   localparam int S_NC = 12, S_ADJ = 13;

   logic [W-1:0] rf_ff [14];
   logic [W-1:0] ma, mb, da, db, alu;
   logic [W-1:0] mres, dres;
   logic [2*W-1:0] prod;
   logic mdone, ddone, mgo, dgo, is_int;
   logic [3:0] mdst_ff;

   function automatic logic [W-1:0] clampv(input logic [FB-1:0] v);
      logic [W-1:0] t;
      t = W'(v);
      if (FB >= W && v > FB'(MAXV)) t = MAXV;
      return t;
   endfunction

   function automatic logic [W-1:0] sadd(input logic [W-1:0] x, input logic [W-1:0] y);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return (s > {1'b0, MAXV}) ? MAXV : s[W-1:0];
   endfunction

   function automatic logic [W-1:0] settle(input logic [W-1:0] p, input logic [W-1:0] n);
      return (p < n || (p - n) < ONE) ? '0 : p - n;
   endfunction

   // multiplier and divider operand select: uop names the product or quotient
   always_comb begin
      ma = '0;
      mb = '0;
      is_int = 1'b0;
      unique case (cmd.uop)
         ppsc_pkg::UOP_MUL_PN: begin ma = rf_ff[S_P]; mb = rf_ff[S_N]; end
         ppsc_pkg::UOP_MUL_PN2: begin ma = rf_ff[S_T]; mb = rf_ff[S_N]; end
         ppsc_pkg::UOP_MUL_TH: begin
            ma = rf_ff[S_PN2];
            mb = W'(reg_th);
            is_int = 1'b1;
         end
         ppsc_pkg::UOP_MUL_AF: begin ma = clampv(reg_a); mb = rf_ff[S_F]; end
         ppsc_pkg::UOP_MUL_GAIN: begin ma = rf_ff[S_T]; mb = rf_ff[S_C]; end
         ppsc_pkg::UOP_MUL_LOSS: begin ma = clampv(reg_d); mb = rf_ff[S_C]; end
         ppsc_pkg::UOP_MUL_RN: begin ma = clampv(reg_r); mb = rf_ff[S_N]; end
         ppsc_pkg::UOP_MUL_EAT: begin ma = rf_ff[S_F]; mb = rf_ff[S_C]; end
         ppsc_pkg::UOP_MUL_ADJ: begin ma = rf_ff[S_RN]; mb = rf_ff[S_ADJ]; end
         default: ;
      endcase
      da = (cmd.uop == ppsc_pkg::UOP_DIV_F) ? rf_ff[S_PN2] : rf_ff[S_N];
      db = (cmd.uop == ppsc_pkg::UOP_DIV_F) ? rf_ff[S_DEN] : clampv(reg_k);
   end

   assign mgo = cmd.op == ppsc_pkg::OP_MUL;
   assign dgo = cmd.op == ppsc_pkg::OP_DIV;

   ppsc_mul #(.WORD_BITS(W)) u_mul (
      .clock(clock), .reset(reset), .go(mgo), .x(ma), .y(mb), .done(mdone), .prod(prod)
   );
   ppsc_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .go(dgo), .x(da), .y(db), .done(ddone), .quo(dres)
   );

   logic is_int_ff, ddst_ff;
   always_comb begin
      if (is_int_ff)
         mres = (prod > (2*W)'(MAXV)) ? MAXV : prod[W-1:0];
      else
         mres = ((prod >> FRAC_BITS) > (2*W)'(MAXV)) ? MAXV : prod[FRAC_BITS+W-1:FRAC_BITS];
   end

   logic [W-1:0] eaten_adj;
   always_comb begin
      alu = '0;
      unique case (cmd.uop)
         ppsc_pkg::UOP_ALU_DEN: alu = sadd(ONE, rf_ff[S_T]);
         ppsc_pkg::UOP_ALU_NC:
            alu = settle(sadd(rf_ff[S_C], rf_ff[S_GAIN]), rf_ff[S_LOSS]);
         ppsc_pkg::UOP_ALU_ADJ:
            alu = (rf_ff[S_RAT] <= ONE) ? ONE - rf_ff[S_RAT] : rf_ff[S_RAT] - ONE;
         default: ;
      endcase
      eaten_adj = (rf_ff[S_RAT] <= ONE)
         ? settle(sadd(rf_ff[S_N], rf_ff[S_T]), rf_ff[S_EAT])
         : settle(rf_ff[S_N], sadd(rf_ff[S_EAT], rf_ff[S_T]));
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ppsc_pkg::OP_LOAD) begin
         rf_ff[S_P] <= clampv(kill_rate);
         rf_ff[S_N] <= clampv(reg_n0);
         rf_ff[S_C] <= clampv(reg_c0);
      end
      if (mgo) begin
         is_int_ff <= is_int;
         unique case (cmd.uop)
            ppsc_pkg::UOP_MUL_PN: mdst_ff <= 4'(S_T);
            ppsc_pkg::UOP_MUL_PN2: mdst_ff <= 4'(S_PN2);
            ppsc_pkg::UOP_MUL_TH: mdst_ff <= 4'(S_T);
            ppsc_pkg::UOP_MUL_AF: mdst_ff <= 4'(S_T);
            ppsc_pkg::UOP_MUL_GAIN: mdst_ff <= 4'(S_GAIN);
            ppsc_pkg::UOP_MUL_LOSS: mdst_ff <= 4'(S_LOSS);
            ppsc_pkg::UOP_MUL_RN: mdst_ff <= 4'(S_RN);
            ppsc_pkg::UOP_MUL_EAT: mdst_ff <= 4'(S_EAT);
            ppsc_pkg::UOP_MUL_ADJ: mdst_ff <= 4'(S_T);
            default: mdst_ff <= 4'(S_T);
         endcase
      end
      if (dgo) ddst_ff <= cmd.uop == ppsc_pkg::UOP_DIV_F;
      if (mdone) rf_ff[mdst_ff] <= mres;
      if (ddone) rf_ff[ddst_ff ? S_F : S_RAT] <= dres;
      if (cmd.op == ppsc_pkg::OP_ALU) begin
         unique case (cmd.uop)
            ppsc_pkg::UOP_ALU_DEN: rf_ff[S_DEN] <= alu;
            ppsc_pkg::UOP_ALU_NC: rf_ff[S_NC] <= alu;
            ppsc_pkg::UOP_ALU_ADJ: rf_ff[S_ADJ] <= alu;
            ppsc_pkg::UOP_ALU_STEP: begin
               rf_ff[S_N] <= eaten_adj;
               rf_ff[S_C] <= rf_ff[S_NC];
            end
            default: ;
         endcase
      end
   end

   assign sts.unit_done = mdone | ddone;
   assign sts.extinct = (rf_ff[S_N] == '0) || (rf_ff[S_C] == '0);
   assign prey = FB'(rf_ff[S_N]);
   assign pred = FB'(rf_ff[S_C]);
endmodule

// ----- rtl/core/ppsc_ctrl.sv -----
module ppsc_ctrl #(
   parameter int STEP_BITS = ppsc_pkg::STEP_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ppsc_pkg::TH_BITS-1:0]   steps,
   output ppsc_pkg::cmd_type              cmd,
   input  ppsc_pkg::sts_type              sts,
   output logic                           finish,
   output logic                           stable,
   output logic [STEP_BITS-1:0]           done_cnt
);
   typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_SETTLE, ST_CHECK} state_type;

   // microcode: op, uop
   localparam int NSEQ = 16;
   function automatic ppsc_pkg::cmd_type seq_op(input logic [3:0] i);
      ppsc_pkg::cmd_type c;
      c.op = ppsc_pkg::OP_MUL;
      c.uop = ppsc_pkg::UOP_MUL_PN;
      unique case (i)
         4'd0: c.uop = ppsc_pkg::UOP_MUL_PN;
         4'd1: c.uop = ppsc_pkg::UOP_MUL_PN2;
         4'd2: c.uop = ppsc_pkg::UOP_MUL_TH;
         4'd3: begin c.op = ppsc_pkg::OP_ALU; c.uop = ppsc_pkg::UOP_ALU_DEN; end
         4'd4: begin c.op = ppsc_pkg::OP_DIV; c.uop = ppsc_pkg::UOP_DIV_F; end
         4'd5: c.uop = ppsc_pkg::UOP_MUL_AF;
         4'd6: c.uop = ppsc_pkg::UOP_MUL_GAIN;
         4'd7: c.uop = ppsc_pkg::UOP_MUL_LOSS;
         4'd8: begin c.op = ppsc_pkg::OP_ALU; c.uop = ppsc_pkg::UOP_ALU_NC; end
         4'd9: begin c.op = ppsc_pkg::OP_DIV; c.uop = ppsc_pkg::UOP_DIV_RAT; end
         4'd10: c.uop = ppsc_pkg::UOP_MUL_RN;
         4'd11: c.uop = ppsc_pkg::UOP_MUL_EAT;
         4'd12: begin c.op = ppsc_pkg::OP_ALU; c.uop = ppsc_pkg::UOP_ALU_ADJ; end
         4'd13: c.uop = ppsc_pkg::UOP_MUL_ADJ;
         4'd14: begin c.op = ppsc_pkg::OP_ALU; c.uop = ppsc_pkg::UOP_ALU_STEP; end
         default: begin c.op = ppsc_pkg::OP_NONE; c.uop = ppsc_pkg::UOP_NONE; end
      endcase
      return c;
   endfunction

   state_type state_ff;
   logic [3:0] pc_ff;
   logic [STEP_BITS-1:0] cnt_ff, lim_ff;
   logic stable_ff, finish_ff;
   ppsc_pkg::cmd_type cmd_ff, cur;

   assign cur = seq_op(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         cnt_ff <= '0;
         stable_ff <= 1'b1;
         finish_ff <= 1'b0;
         cmd_ff <= '{op: ppsc_pkg::OP_NONE, uop: ppsc_pkg::UOP_NONE};
      end else begin
         finish_ff <= 1'b0;
         cmd_ff <= '{op: ppsc_pkg::OP_NONE, uop: ppsc_pkg::UOP_NONE};
         unique case (state_ff)
            ST_IDLE: if (start) begin
               cmd_ff <= '{op: ppsc_pkg::OP_LOAD, uop: ppsc_pkg::UOP_NONE};
               lim_ff <= STEP_BITS'(steps);
               cnt_ff <= '0;
               pc_ff <= '0;
               stable_ff <= 1'b1;
               state_ff <= ST_CHECK;
            end
            ST_ISSUE: begin
               cmd_ff <= cur;
               pc_ff <= pc_ff + 4'd1;
               if (cur.op == ppsc_pkg::OP_ALU) begin
                  if (pc_ff == 4'(NSEQ - 2)) begin
                     cnt_ff <= cnt_ff + 1'b1;
                     state_ff <= ST_SETTLE;
                  end
               end else state_ff <= ST_WAIT;
            end
            ST_WAIT: if (sts.unit_done) state_ff <= ST_ISSUE;
            ST_SETTLE: state_ff <= ST_CHECK;
            ST_CHECK: begin
               pc_ff <= '0;
               if (cnt_ff != '0 && sts.extinct) begin
                  stable_ff <= 1'b0;
                  finish_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (cnt_ff == lim_ff) begin
                  finish_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else state_ff <= ST_ISSUE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = state_ff != ST_IDLE;
   assign cmd = cmd_ff;
   assign finish = finish_ff;
   assign stable = stable_ff;
   assign done_cnt = cnt_ff;

   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      finish |-> state_ff == ST_IDLE) else $error("finish outside idle");
   a_cnt_lim: assert property (@(posedge clock) disable iff (reset)
      busy |-> cnt_ff <= lim_ff) else $error("step count past limit");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
endmodule

// ----- rtl/core/predator_prey_stability_check.sv -----
// Each step runs nine multiplies on the shared multiplier, two bit-serial divides
// on the serial divider, then its update, settle and check.
// Throughput: one kill rate at a time; busy stays high until the result strobe cycle.
// The receiver cannot stall; the result strobe lasts one cycle.
// Reset (synchronous): the configuration registers return to their defaults, the block goes idle.
module predator_prey_stability_check #(
   parameter int WORD_BITS = ppsc_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = ppsc_pkg::FRAC_BITS_DEF,
   parameter int STEP_BITS = ppsc_pkg::STEP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]     req_kill_rate,
   output logic                                rsp_valid,
   output logic [ppsc_pkg::FIELD_BITS-1:0]     rsp_tested_rate,
   output logic                                rsp_stable,
   output logic [ppsc_pkg::TH_BITS-1:0]        rsp_steps_done,
   output logic [ppsc_pkg::FIELD_BITS-1:0]     rsp_final_prey,
   output logic [ppsc_pkg::FIELD_BITS-1:0]     rsp_final_predator,
   input  logic                                csr_we,
   input  logic [ppsc_pkg::CFG_IDX_BITS-1:0]   csr_index,
   input  logic [ppsc_pkg::FIELD_BITS-1:0]     csr_wdata
);
   localparam int FB = ppsc_pkg::FIELD_BITS;
   localparam int TB = ppsc_pkg::TH_BITS;

   logic [FB-1:0] r_ff, k_ff, d_ff, a_ff, n0_ff, c0_ff, rate_ff;
   logic [TB-1:0] th_ff, steps_ff;
   ppsc_pkg::cmd_type cmd;
   ppsc_pkg::sts_type sts;
   logic finish, stable;
   logic [STEP_BITS-1:0] done_cnt;
   logic [FB-1:0] prey, pred;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= ppsc_pkg::RST_R;
         k_ff <= ppsc_pkg::RST_K;
         d_ff <= ppsc_pkg::RST_D;
         a_ff <= ppsc_pkg::RST_A;
         th_ff <= ppsc_pkg::RST_TH;
         n0_ff <= ppsc_pkg::RST_N0;
         c0_ff <= ppsc_pkg::RST_C0;
         steps_ff <= ppsc_pkg::RST_STEPS;
      end else if (csr_we) begin
         unique case (csr_index)
            ppsc_pkg::REG_R: r_ff <= csr_wdata;
            ppsc_pkg::REG_K: k_ff <= csr_wdata;
            ppsc_pkg::REG_D: d_ff <= csr_wdata;
            ppsc_pkg::REG_A: a_ff <= csr_wdata;
            ppsc_pkg::REG_TH: th_ff <= csr_wdata[TB-1:0];
            ppsc_pkg::REG_N0: n0_ff <= csr_wdata;
            ppsc_pkg::REG_C0: c0_ff <= csr_wdata;
            ppsc_pkg::REG_STEPS: steps_ff <= csr_wdata[TB-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) rate_ff <= req_kill_rate;
   end

   ppsc_ctrl #(.STEP_BITS(STEP_BITS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .steps(steps_ff),
      .cmd(cmd), .sts(sts), .finish(finish), .stable(stable), .done_cnt(done_cnt)
   );

   ppsc_datapath #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .kill_rate(rate_ff),
      .reg_r(r_ff), .reg_k(k_ff), .reg_d(d_ff), .reg_a(a_ff), .reg_th(th_ff),
      .reg_n0(n0_ff), .reg_c0(c0_ff), .prey(prey), .pred(pred)
   );

   assign rsp_valid = finish;
   assign rsp_tested_rate = rate_ff;
   assign rsp_stable = stable;
   assign rsp_steps_done = TB'(done_cnt);
   assign rsp_final_prey = prey;
   assign rsp_final_predator = pred;
endmodule
